### rtl/gwm_pkg.sv
// gwm_pkg: shared constants and types for the glob matcher
// used by gwm_cell and wildcard_glob_matcher_core, no dependencies
`default_nettype none

package gwm_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int BYTE_W          = 8;
	localparam int REG_W           = 64;
	localparam int LEN_W           = 6;
	localparam int IDX_W           = 3;
	localparam int PAT_BYTES       = 4 * REG_W / BYTE_W;

	localparam logic [BYTE_W-1:0] CHAR_QMARK = 8'h3F;
	localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;

	localparam logic [IDX_W-1:0] REG_PAT_A = 3'd0;
	localparam logic [IDX_W-1:0] REG_PAT_B = 3'd1;
	localparam logic [IDX_W-1:0] REG_PAT_C = 3'd2;
	localparam logic [IDX_W-1:0] REG_PAT_D = 3'd3;
	localparam logic [IDX_W-1:0] REG_LEN   = 3'd4;

	// signals handed from one cell to the next
	typedef struct packed {
		logic start;
		logic into;
	} link_t;

	// per-position view of the active set
	typedef struct packed {
		logic cur;
		logic nxt;
	} cell_stat_t;

endpackage

`default_nettype wire

### rtl/gwm_cell.sv
// gwm_cell: one pattern position of the glob matcher cell row
// depends on gwm_pkg for byte constants and link types
`default_nettype none

module gwm_cell
	import gwm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] pat_byte,
	input  wire logic              en,
	input  wire logic [BYTE_W-1:0] subj,
	input  wire logic              fresh,
	input  wire logic              step,
	input  wire link_t             link_in,
	output link_t                  link_out,
	output cell_stat_t             stat
);

	logic act_q;
	logic star;
	logic hit;
	logic cur;
	logic cl;

	always_comb begin
		star = en && (pat_byte == CHAR_STAR);
		hit  = (pat_byte == CHAR_QMARK) || (pat_byte == subj);
		cur  = fresh ? link_in.start : act_q;
		cl   = (cur & star) | link_in.into;
		link_out.start = link_in.start & star;
		link_out.into  = (cur & en & ~star & hit) | (cl & star);
		stat.cur = cur;
		stat.nxt = cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (step) begin
			act_q <= cl;
		end
	end

endmodule

`default_nettype wire

### rtl/wildcard_glob_matcher_core.sv
// wildcard_glob_matcher_core: top level of the streaming glob matcher
// depends on gwm_pkg and instantiates a row of gwm_cell
//
// Matches a streamed subject, one byte per transaction, against a stored glob
// pattern of up to PATTERN_MAX bytes ('?' any byte, '*' any run). One subject
// byte is taken every clock cycle with no gaps between subjects; the whole
// active-position update, star closure included, ripples combinationally
// through the cell row. The result of a subject's last transaction is
// registered in the output register when that register is free. A two-entry
// output buffer keeps input flowing while one result waits; input stalls only
// while both entries hold results. Any write to a pattern register or to the
// length register restarts the subject in progress.
`default_nettype none

module wildcard_glob_matcher_core
	import gwm_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_index,
	input  wire logic [REG_W-1:0]  wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] subject_byte,
	input  wire logic              end_of_subject,
	input  wire logic              empty_subject,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   matched
);

	localparam int POS_W = $clog2(PATTERN_MAX + 1);

	logic [3:0][REG_W-1:0]             pat_q;
	logic [LEN_W-1:0]                  plen_q;
	logic                              fresh_q;
	logic                              act_last_q;
	logic                              out_valid_q;
	logic                              out_data_q;
	logic                              skid_valid_q;
	logic                              skid_data_q;

	logic [PAT_BYTES-1:0][BYTE_W-1:0]  pat_bytes;
	logic [LEN_W-1:0]                  len;
	logic [POS_W-1:0]                  pos;
	link_t [PATTERN_MAX:0]             link;
	cell_stat_t [PATTERN_MAX:0]        stat;
	logic                              accept;
	logic                              step;
	logic                              res_v;
	logic                              res_d;
	logic                              out_take;
	logic                              cfg_hit;

	assign link[0].start = 1'b1;
	assign link[0].into  = 1'b0;
	assign stat[PATTERN_MAX].cur = fresh_q ? link[PATTERN_MAX].start : act_last_q;
	assign stat[PATTERN_MAX].nxt = link[PATTERN_MAX].into;

	always_comb begin
		pat_bytes = pat_q;
		len = (plen_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : plen_q;
		pos = len[POS_W-1:0];
		accept   = in_valid && !in_stall;
		step     = accept && !empty_subject;
		res_v    = accept && (empty_subject || end_of_subject);
		res_d    = empty_subject ? stat[pos].cur : stat[pos].nxt;
		out_take = out_valid_q && !out_stall;
		cfg_hit  = wr_en && (wr_index <= REG_LEN);
		in_stall  = skid_valid_q;
		out_valid = out_valid_q;
		matched   = out_data_q;
	end

	for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
		gwm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pat_byte (pat_bytes[g]),
			.en       (len > LEN_W'(g)),
			.subj     (subject_byte),
			.fresh    (fresh_q),
			.step     (step),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.stat     (stat[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PAT_A: pat_q[0] <= wr_data;
				REG_PAT_B: pat_q[1] <= wr_data;
				REG_PAT_C: pat_q[2] <= wr_data;
				REG_PAT_D: pat_q[3] <= wr_data;
				REG_LEN:   plen_q   <= wr_data[LEN_W-1:0];
				default:   ;
			endcase
		end
	end

	// restart on a write to any listed register, index beyond the list ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q    <= 1'b1;
			act_last_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				fresh_q <= 1'b1;
			end else if (accept) begin
				fresh_q <= empty_subject || end_of_subject;
			end
			if (step) begin
				act_last_q <= link[PATTERN_MAX].into;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || res_v;
			skid_valid_q <= 1'b0;
		end else if (res_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : res_d;
		end else if (res_v) begin
			skid_data_q <= res_d;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_result_follows_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_v |=> out_valid_q)
		else $error("ending transaction gave no result");

	a_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> fresh_q)
		else $error("register write did not restart the subject");

	a_fresh_pos0: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> stat[0].cur)
		else $error("restart state lost position zero");

endmodule

`default_nettype wire
